FILE: hdl/rtpfu_pkg.sv
// ----------------------------------------------------------------------------
// rtpfu_pkg
// Shared constants and types of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package rtpfu_pkg;

	// fixed field widths
	localparam int LEN_W   = 21;            // unit length / byte position
	localparam int AT_W    = LEN_W + 1;     // remaining bytes plus fragment fill
	localparam int PLEN_W  = 11;            // packet length field
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// fragmentation
	localparam int FRAG_PAYLOAD   = 1400;
	localparam int FILL_W         = $clog2(FRAG_PAYLOAD);
	localparam int MAX_UNIT_BYTES = 1048576;
	localparam logic [LEN_W-1:0] MAX_UNIT_LEN = LEN_W'(MAX_UNIT_BYTES);

	// packet layout
	localparam int RTP_HDR_BYTES = 12;
	localparam int FU_HDR_BYTES  = 14;
	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
	localparam logic [4:0] FU_A_TYPE = 5'd28;

	// start code lengths
	localparam logic [2:0] START_CODE_NONE  = 3'd0;
	localparam logic [2:0] START_CODE_SHORT = 3'd3;
	localparam logic [2:0] START_CODE_LONG  = 3'd4;

	// positions within a header burst
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] RTP_LAST_IDX    = STEP_W'(RTP_HDR_BYTES - 1);
	localparam logic [STEP_W-1:0] SINGLE_LAST_IDX = STEP_W'(RTP_HDR_BYTES);
	localparam logic [STEP_W-1:0] FU_IND_IDX      = STEP_W'(RTP_HDR_BYTES);
	localparam logic [STEP_W-1:0] FU_LAST_IDX     = STEP_W'(FU_HDR_BYTES);

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_SRC_ID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP_STEP = 2'd2;

	typedef enum logic [1:0] {
		CMD_ERROR,
		CMD_BYTE,
		CMD_SINGLE_HDR,
		CMD_FU_HDR
	} cmd_kind_t;

	// one command per input byte that produces output
	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        data;
		logic              pend;
		logic [PLEN_W-1:0] plen;
		logic              marker;
		logic [7:0]        fu_ind;
		logic [7:0]        fu_hdr;
		logic [31:0]       timestamp;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic [7:0]        packet_byte;
		logic              packet_start;
		logic              packet_end;
		logic [PLEN_W-1:0] packet_length;
		logic              start_code_error;
		logic              run_last;
	} result_t;

endpackage

FILE: hdl/rtpfu_if.sv
// ----------------------------------------------------------------------------
// rtpfu_in_if / rtpfu_out_if
// Valid/ready channels for unit bytes in and packet bytes out.
// ----------------------------------------------------------------------------
interface rtpfu_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [20:0] unit_length;
	logic        unit_end;

	modport source (output valid, data_byte, unit_length, unit_end, input ready);
	modport sink   (input valid, data_byte, unit_length, unit_end, output ready);
endinterface

interface rtpfu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  packet_byte;
	logic        packet_start;
	logic        packet_end;
	logic [10:0] packet_length;
	logic        start_code_error;
	logic        run_last;

	modport source (output valid, packet_byte, packet_start, packet_end, packet_length,
		start_code_error, run_last, input ready);
	modport sink   (input valid, packet_byte, packet_start, packet_end, packet_length,
		start_code_error, run_last, output ready);
endinterface

FILE: hdl/rtpfu_front.sv
// ----------------------------------------------------------------------------
// rtpfu_front
// Parses unit bytes: start code search, NAL header latch, fragmentation.
// Emits one command per byte that produces packet output.
// ----------------------------------------------------------------------------
module rtpfu_front (
	input  logic                clk,
	input  logic                arst_n,
	rtpfu_in_if.sink            nal_in,
	input  logic [31:0]         timestamp_step,
	input  logic                fifo_full,
	output rtpfu_pkg::push_t    push
);
	import rtpfu_pkg::*;

	logic [LEN_W-1:0]  pos_q, pos_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [2:0]        prefix_q, prefix_d;
	logic              drop_q, drop_d;
	logic [7:0]        nal_q, nal_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [31:0]       ts_q, ts_d;

	logic              accept;
	logic [7:0]        b;
	logic [LEN_W-1:0]  sat_len, eff_len, pos_inc;
	logic              load_len, in_unit, last;
	logic              found3, found4, bad;
	logic [LEN_W-1:0]  nal_len, payload, rem;
	logic              single, at_hdr, first_frag, is_last_frag, pend;
	logic [AT_W-1:0]   at_start;
	logic [PLEN_W-1:0] sgl_plen, fu_plen, frag_len;
	logic [31:0]       ts_sum;
	push_t             push_d;

	assign nal_in.ready = !fifo_full;
	assign accept = nal_in.valid && nal_in.ready;
	assign b = nal_in.data_byte;

	assign sat_len  = (nal_in.unit_length > MAX_UNIT_LEN) ? MAX_UNIT_LEN : nal_in.unit_length;
	assign load_len = (pos_q == '0) && !drop_q;
	assign eff_len  = load_len ? sat_len : len_q;
	assign pos_inc  = pos_q + LEN_W'(1);
	assign in_unit  = pos_q < eff_len;
	assign last     = nal_in.unit_end || (pos_inc == eff_len);

	// start code search
	assign found3 = (pos_q == LEN_W'(2)) && (b == 8'd1);
	assign found4 = (pos_q >= LEN_W'(3)) && (b == 8'd1);
	assign bad    = ((pos_q < LEN_W'(2)) && (b != 8'd0))
		|| ((pos_q == LEN_W'(2)) && (b > 8'd1))
		|| ((pos_q >= LEN_W'(3)) && (b != 8'd1));

	// payload side; position is past the start code here, so len_q is current
	assign nal_len  = len_q - LEN_W'(prefix_q);
	assign payload  = nal_len - LEN_W'(1);
	assign single   = payload <= LEN_W'(FRAG_PAYLOAD);
	assign sgl_plen = PLEN_W'(nal_len + LEN_W'(RTP_HDR_BYTES));
	assign at_hdr   = pos_q == LEN_W'(prefix_q);
	assign first_frag = pos_q == (LEN_W'(prefix_q) + LEN_W'(1));
	assign rem      = len_q - pos_q;
	assign at_start = AT_W'(rem) + AT_W'(fill_q);
	assign is_last_frag = at_start <= AT_W'(FRAG_PAYLOAD);
	assign frag_len = is_last_frag ? at_start[PLEN_W-1:0] : PLEN_W'(FRAG_PAYLOAD);
	assign fu_plen  = frag_len + PLEN_W'(FU_HDR_BYTES);
	assign pend     = last || (rem == LEN_W'(1)) || (fill_q >= FILL_W'(FRAG_PAYLOAD - 1));
	assign ts_sum   = ts_q + timestamp_step;

	always_comb begin
		pos_d    = pos_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		drop_d   = drop_q;
		nal_d    = nal_q;
		fill_d   = fill_q;
		ts_d     = ts_q;
		push_d   = '0;
		push_d.cmd.kind = CMD_ERROR;
		push_d.cmd.data = b;
		push_d.cmd.pend = last;
		push_d.cmd.fu_ind = {nal_q[7:5], FU_A_TYPE};
		push_d.cmd.fu_hdr = {first_frag, is_last_frag, 1'b0, nal_q[4:0]};
		push_d.cmd.timestamp = ts_q;
		if (accept) begin
			if (load_len) begin
				len_d = sat_len;
			end
			if (drop_q) begin
				// discard until unit_end
			end else if (in_unit) begin
				pos_d = pos_inc;
				if (prefix_q == START_CODE_NONE) begin
					if (found3) begin
						prefix_d = START_CODE_SHORT;
					end else if (found4) begin
						prefix_d = START_CODE_LONG;
					end else if (bad || last) begin
						drop_d = 1'b1;
						push_d.valid = 1'b1;
						push_d.cmd = '0;
						push_d.cmd.kind = CMD_ERROR;
					end
				end else if (at_hdr) begin
					nal_d = b;
					ts_d  = ts_sum;
					if (single) begin
						push_d.valid = 1'b1;
						push_d.cmd.kind = CMD_SINGLE_HDR;
						push_d.cmd.plen = sgl_plen;
						push_d.cmd.marker = 1'b1;
						push_d.cmd.timestamp = ts_sum;
					end
				end else if (single) begin
					push_d.valid = 1'b1;
					push_d.cmd.kind = CMD_BYTE;
					push_d.cmd.plen = sgl_plen;
				end else begin
					push_d.valid = 1'b1;
					push_d.cmd.kind = (fill_q == '0) ? CMD_FU_HDR : CMD_BYTE;
					push_d.cmd.plen = fu_plen;
					push_d.cmd.pend = pend;
					push_d.cmd.marker = is_last_frag;
					fill_d = pend ? '0 : fill_q + FILL_W'(1);
				end
			end else if ((pos_q == '0) && (eff_len == '0)) begin
				drop_d = 1'b1;
				push_d.valid = 1'b1;
				push_d.cmd = '0;
				push_d.cmd.kind = CMD_ERROR;
			end
			if (nal_in.unit_end) begin
				pos_d    = '0;
				prefix_d = START_CODE_NONE;
				fill_d   = '0;
				drop_d   = 1'b0;
			end
		end
	end

	assign push = push_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			prefix_q <= START_CODE_NONE;
			drop_q   <= 1'b0;
			nal_q    <= '0;
			fill_q   <= '0;
			ts_q     <= '0;
		end else begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			drop_q   <= drop_d;
			nal_q    <= nal_d;
			fill_q   <= fill_d;
			ts_q     <= ts_d;
		end
	end

endmodule

FILE: hdl/rtpfu_fifo.sv
// ----------------------------------------------------------------------------
// rtpfu_fifo
// Short command queue between the parser and the packet sequencer.
// ----------------------------------------------------------------------------
module rtpfu_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtpfu_pkg::push_t          push,
	input  logic                      pop,
	output rtpfu_pkg::cmd_t           head,
	output rtpfu_pkg::fifo_status_t   status
);
	import rtpfu_pkg::*;

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign status.full  = count_q == (PTR_W+1)'(FIFO_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push = push.valid && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/rtpfu_back.sv
// ----------------------------------------------------------------------------
// rtpfu_back
// Expands commands into packet bytes: RTP header, FU-A bytes, payload.
// Owns the sequence number and the output register.
// ----------------------------------------------------------------------------
module rtpfu_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rtpfu_pkg::cmd_t          head,
	input  rtpfu_pkg::fifo_status_t  status,
	input  logic [6:0]               payload_type,
	input  logic [31:0]              stream_source_id,
	output logic                     pop,
	rtpfu_out_if.source              rtp_out
);
	import rtpfu_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [15:0]       seq_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              load, emit, is_hdr, at_last;
	logic [STEP_W-1:0] last_idx;
	logic [7:0]        hdr_bytes [RTP_HDR_BYTES];
	result_t           res;

	assign load = !out_valid_q || rtp_out.ready;
	assign emit = !status.empty && load;
	assign is_hdr = (head.kind == CMD_SINGLE_HDR) || (head.kind == CMD_FU_HDR);

	always_comb begin
		unique case (head.kind)
			CMD_SINGLE_HDR: last_idx = SINGLE_LAST_IDX;
			CMD_FU_HDR:     last_idx = FU_LAST_IDX;
			default:        last_idx = '0;
		endcase
	end

	assign at_last = step_q == last_idx;

	assign hdr_bytes[0]  = RTP_VERSION_BYTE;
	assign hdr_bytes[1]  = {head.marker, payload_type};
	assign hdr_bytes[2]  = seq_q[15:8];
	assign hdr_bytes[3]  = seq_q[7:0];
	assign hdr_bytes[4]  = head.timestamp[31:24];
	assign hdr_bytes[5]  = head.timestamp[23:16];
	assign hdr_bytes[6]  = head.timestamp[15:8];
	assign hdr_bytes[7]  = head.timestamp[7:0];
	assign hdr_bytes[8]  = stream_source_id[31:24];
	assign hdr_bytes[9]  = stream_source_id[23:16];
	assign hdr_bytes[10] = stream_source_id[15:8];
	assign hdr_bytes[11] = stream_source_id[7:0];

	always_comb begin
		res = '0;
		res.packet_start     = is_hdr && (step_q == '0);
		res.packet_end       = at_last && head.pend;
		res.packet_length    = head.plen;
		res.start_code_error = head.kind == CMD_ERROR;
		res.run_last         = at_last;
		if (!is_hdr || at_last) begin
			res.packet_byte = head.data;
		end else if (step_q <= RTP_LAST_IDX) begin
			res.packet_byte = hdr_bytes[step_q];
		end else if (step_q == FU_IND_IDX) begin
			res.packet_byte = head.fu_ind;
		end else begin
			res.packet_byte = head.fu_hdr;
		end
	end

	assign pop = emit && at_last;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			seq_q       <= 16'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !status.empty;
			end
			if (emit) begin
				step_q <= at_last ? '0 : step_q + STEP_W'(1);
				if (is_hdr && (step_q == RTP_LAST_IDX)) begin
					seq_q <= seq_q + 16'd1;
				end
			end
		end
	end

	assign rtp_out.valid            = out_valid_q;
	assign rtp_out.packet_byte      = out_q.packet_byte;
	assign rtp_out.packet_start     = out_q.packet_start;
	assign rtp_out.packet_end       = out_q.packet_end;
	assign rtp_out.packet_length    = out_q.packet_length;
	assign rtp_out.start_code_error = out_q.start_code_error;
	assign rtp_out.run_last         = out_q.run_last;

endmodule

FILE: hdl/h264_rtp_fua_packetizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// Annex-B byte stream in, RTP packets (single NAL or FU-A fragments) out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  nal_in    in   valid/ready      data_byte, unit_length, unit_end
//  rtp_out   out  valid/ready      packet_byte, packet_start, packet_end,
//                                  packet_length, start_code_error, run_last
//  cfg       in   cfg_wr_en        cfg_index, cfg_data (no read-back)
//
//  Input takes one byte per cycle unless the queue is full; one command is
//  made per byte that produces output. Output gives one byte per cycle when
//  not stalled; the RTP header (and for FU-A the FU indicator and FU header)
//  goes before a byte that opens a packet. A 4-entry command queue lets input
//  run on during a header burst; input stalls only when the queue fills.
//  Reset clears parser state, queue and output; sequence number restarts at 1.
//  Output stalls hold the output register and back up through the queue.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rtpfu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtpfu_pkg::CFG_DATA_W-1:0]    cfg_data,
	rtpfu_in_if.sink                            nal_in,
	rtpfu_out_if.source                         rtp_out
);
	import rtpfu_pkg::*;

	// configuration registers
	logic [6:0]  payload_type_q;
	logic [31:0] stream_source_id_q;
	logic [31:0] timestamp_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_type_q     <= 7'd96;
			stream_source_id_q <= 32'd18;
			timestamp_step_q   <= 32'd3000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PAYLOAD_TYPE:   payload_type_q     <= cfg_data[6:0];
				CFG_STREAM_SRC_ID:  stream_source_id_q <= cfg_data;
				CFG_TIMESTAMP_STEP: timestamp_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	push_t        push;
	cmd_t         head;
	fifo_status_t fifo_status;
	logic         pop;

	// front: start code check, header latch, fragment bookkeeping
	rtpfu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.nal_in         (nal_in),
		.timestamp_step (timestamp_step_q),
		.fifo_full      (fifo_status.full),
		.push           (push)
	);

	rtpfu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (fifo_status)
	);

	// back: header bursts and payload bytes, one per cycle when not stalled
	rtpfu_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.status           (fifo_status),
		.payload_type     (payload_type_q),
		.stream_source_id (stream_source_id_q),
		.pop              (pop),
		.rtp_out          (rtp_out)
	);

	// parser never pushes into a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !fifo_status.full)
		else $error("command pushed into full queue");

	a_fifo_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_status.full && fifo_status.empty))
		else $error("queue full and empty at once");

	// every packet opens with the RTP version byte
	a_packet_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rtp_out.valid && rtp_out.packet_start |->
			rtp_out.packet_byte == RTP_VERSION_BYTE && !rtp_out.start_code_error)
		else $error("packet start without RTP version byte");

	// an error request stands alone with all other fields clear
	a_error_request: assert property (@(posedge clk) disable iff (!arst_n)
		rtp_out.valid && rtp_out.start_code_error |->
			rtp_out.run_last && rtp_out.packet_length == '0 && rtp_out.packet_byte == '0
			&& !rtp_out.packet_start && !rtp_out.packet_end)
		else $error("malformed start code error request");

endmodule
